// ===== src/case_range_overlap_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the case range overlap table
// Shared clocked property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CASE_RANGE_OVERLAP_TABLE_ASSERT_SVH
`define CASE_RANGE_OVERLAP_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CROT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CROT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/crot_pkg.sv =====
// ----------------------------------------------------------------------------
// crot_pkg
// Types, codes and interval rules shared by the case range overlap table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crot_pkg;

    localparam int MAX_CASES = 64;

    localparam logic [1:0] MODE_CHECK = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] KIND_VAL = 2'd0;
    localparam logic [1:0] KIND_MIN = 2'd1;
    localparam logic [1:0] KIND_MAX = 2'd2;
    localparam logic [1:0] KIND_RNG = 2'd3;

    typedef struct packed {
        logic [1:0]          mode;
        logic [1:0]          case_kind;
        logic signed [31:0]  low_bound;
        logic signed [31:0]  high_bound;
    } in_item_t;

    typedef struct packed {
        logic       overlap_found;
        logic [6:0] insert_position;
        logic       table_full;
        logic [6:0] entry_count;
    } result_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic signed [31:0]  low;
        logic signed [31:0]  high;
    } entry_t;

    typedef struct packed {
        logic compare;
        logic load_new;
        logic take_prev;
    } cell_ctrl_t;

    typedef struct packed {
        logic overlap;
        logic above;
    } cell_flags_t;

    typedef enum logic {
        ST_IDLE,
        ST_SHIFT
    } state_t;

    // Does the new interval overlap a stored entry?
    function automatic logic overlaps(input entry_t n, input entry_t e, input logic exact);
        logic r;
        r = 1'b0;
        if (exact)
        begin
            r = (n.kind == KIND_VAL) && (e.kind == KIND_VAL) && (n.low == e.low);
        end
        else
        begin
            case (n.kind)
                KIND_VAL:
                begin
                    case (e.kind)
                        KIND_VAL: r = (n.low == e.low);
                        KIND_MIN: r = (n.low >= e.low);
                        KIND_MAX: r = (n.low <= e.high);
                        default:  r = (n.low >= e.low) && (n.low <= e.high);
                    endcase
                end
                KIND_MIN:
                begin
                    case (e.kind)
                        KIND_VAL: r = (n.low <= e.low);
                        KIND_MIN: r = 1'b1;
                        default:  r = (n.low <= e.high);
                    endcase
                end
                KIND_MAX:
                begin
                    case (e.kind)
                        KIND_MAX: r = 1'b1;
                        default:  r = (n.high >= e.low);
                    endcase
                end
                default:
                begin
                    case (e.kind)
                        KIND_VAL: r = (n.low <= e.low) && (n.high >= e.low);
                        KIND_MIN: r = (n.high >= e.low);
                        KIND_MAX: r = (n.low <= e.high);
                        default:  r = (n.low <= e.high) && (n.high >= e.low);
                    endcase
                end
            endcase
        end
        return r;
    endfunction

    // Does the stored entry sort above the new interval?
    function automatic logic entry_above(input entry_t n, input entry_t e);
        logic r;
        r = 1'b0;
        case (e.kind)
            KIND_VAL:
            begin
                case (n.kind)
                    KIND_VAL: r = (n.low < e.low);
                    KIND_MIN: r = 1'b0;
                    KIND_MAX: r = (e.low > n.high);
                    default:  r = !(e.low < n.low) && (e.low > n.high);
                endcase
            end
            KIND_MIN:
            begin
                case (n.kind)
                    KIND_VAL: r = (e.low > n.low);
                    KIND_MIN: r = 1'b0;
                    default:  r = (e.low > n.high);
                endcase
            end
            KIND_MAX:
            begin
                r = 1'b0;
            end
            default:
            begin
                case (n.kind)
                    KIND_VAL: r = !(e.high < n.low) && (e.low > n.low);
                    KIND_MIN: r = 1'b0;
                    KIND_MAX: r = (e.low > n.high);
                    default:  r = !(e.high < n.low) && (e.low > n.high);
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

// ===== src/crot_cell.sv =====
// ----------------------------------------------------------------------------
// crot_cell
// One table slot: holds an interval, compares it with the broadcast item and
// shifts toward the next slot on insertion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crot_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  crot_pkg::cell_ctrl_t  ctrl,
    input  logic                  exact_only,
    input  crot_pkg::entry_t      probe,
    input  crot_pkg::entry_t      new_entry,
    input  crot_pkg::entry_t      prev_entry,
    output crot_pkg::entry_t      entry,
    output crot_pkg::cell_flags_t flags
);

    crot_pkg::entry_t      entry_reg;
    crot_pkg::entry_t      entry_next;
    crot_pkg::cell_flags_t flags_reg;
    crot_pkg::cell_flags_t flags_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load_new)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.take_prev)
        begin
            entry_next = prev_entry;
        end
    end

    always_comb
    begin
        flags_next = flags_reg;
        if (ctrl.compare)
        begin
            flags_next.overlap = crot_pkg::overlaps(probe, entry_reg, exact_only);
            flags_next.above   = crot_pkg::entry_above(probe, entry_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign entry = entry_reg;
    assign flags = flags_reg;

endmodule

// ===== src/case_range_overlap_table.sv =====
// ----------------------------------------------------------------------------
// case_range_overlap_table
// Ordered table of switch-case intervals with overlap check and sorted insert.
// ----------------------------------------------------------------------------
// Usage:
//   An item (mode, kind, bounds) is taken at a clock edge where start is high
//   and busy is low. At that edge every cell compares the item with its own
//   entry and latches an overlap flag and an ordering flag. In the following
//   cycle busy is high; at its closing edge the insertion point is found from
//   the flags and, for an add to a table that is not full, the cells shift
//   one place toward the end and the new interval is written; the result is
//   registered. done rises at the closing edge of the busy cycle and is high
//   for exactly one cycle, so the result is taken at the edge that ends it.
//   No new item is taken while busy is high: the next item may be accepted at
//   the closing edge of the done cycle.
//   The receiver cannot stall: done marks each result for one cycle only.
//   The exact_only register is written through cfg_we and cfg_wdata; the user
//   must write it only while the block is idle, which the block does not enforce.
//   Reset empties the table and clears exact_only; entry contents are not
//   cleared, since slots at or above the count are never consulted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module case_range_overlap_table #(
    parameter int MAX_CASES = crot_pkg::MAX_CASES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  crot_pkg::in_item_t item,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    output logic               done,
    output crot_pkg::result_t  result
);

    localparam int CNT_W = $clog2(MAX_CASES + 1);
    localparam int PAD_W = CNT_W + 7;

    crot_pkg::state_t      state_reg;
    crot_pkg::state_t      state_next;
    logic                  accept;
    logic                  do_shift;
    logic                  do_insert;
    logic                  full;

    logic                  exact_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    crot_pkg::in_item_t    req_reg;
    crot_pkg::result_t     result_reg;
    crot_pkg::result_t     result_next;
    logic                  done_reg;

    crot_pkg::entry_t      probe;
    crot_pkg::entry_t      req_entry;
    crot_pkg::entry_t      entries [MAX_CASES];
    crot_pkg::cell_flags_t flags   [MAX_CASES];
    crot_pkg::cell_ctrl_t  ctrl    [MAX_CASES];
    logic [MAX_CASES-1:0]  mark;
    logic [MAX_CASES-1:0]  hit;
    logic [MAX_CASES-1:0]  first;
    logic [MAX_CASES:0]    marked_below;
    logic [CNT_W-1:0]      pos;
    logic [PAD_W-1:0]      pos_pad;
    logic [PAD_W-1:0]      cnt_pad;

    assign accept = start && !busy;

    // State machine: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crot_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = crot_pkg::ST_SHIFT;
                end
            end
            crot_pkg::ST_SHIFT:
            begin
                state_next = crot_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = crot_pkg::ST_IDLE;
            end
        endcase
    end

    // State machine: outputs.
    always_comb
    begin
        busy     = 1'b0;
        do_shift = 1'b0;
        case (state_reg)
            crot_pkg::ST_SHIFT:
            begin
                busy     = 1'b1;
                do_shift = 1'b1;
            end
            default:
            begin
                busy     = 1'b0;
                do_shift = 1'b0;
            end
        endcase
    end

    assign probe.kind = item.case_kind;
    assign probe.low  = item.low_bound;
    assign probe.high = item.high_bound;

    assign req_entry.kind = req_reg.case_kind;
    assign req_entry.low  = req_reg.low_bound;
    assign req_entry.high = req_reg.high_bound;

    assign full      = (count_reg == CNT_W'(MAX_CASES));
    assign do_insert = do_shift && (req_reg.mode == crot_pkg::MODE_ADD) && !full;

    assign marked_below[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < MAX_CASES; i++)
        begin : g_cell
            logic occupied;

            assign occupied = (CNT_W'(i) < count_reg);
            // The slot just past the last entry also marks, so an interval
            // with nothing above it lands at the end.
            assign mark[i]           = (flags[i].above && occupied) || (CNT_W'(i) == count_reg);
            assign hit[i]            = flags[i].overlap && occupied;
            assign marked_below[i+1] = marked_below[i] || mark[i];
            assign first[i]          = mark[i] && !marked_below[i];

            assign ctrl[i].compare   = accept;
            assign ctrl[i].load_new  = do_insert && first[i];
            assign ctrl[i].take_prev = do_insert && marked_below[i];

            if (i == 0)
            begin : g_head
                crot_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl[i]),
                    .exact_only (exact_reg),
                    .probe      (probe),
                    .new_entry  (req_entry),
                    .prev_entry (req_entry),
                    .entry      (entries[i]),
                    .flags      (flags[i])
                );
            end
            else
            begin : g_body
                crot_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl[i]),
                    .exact_only (exact_reg),
                    .probe      (probe),
                    .new_entry  (req_entry),
                    .prev_entry (entries[i-1]),
                    .entry      (entries[i]),
                    .flags      (flags[i])
                );
            end
        end
    endgenerate

    // Binary index of the single first marked slot.
    always_comb
    begin
        pos = '0;
        for (int k = 0; k < MAX_CASES; k++)
        begin
            if (first[k])
            begin
                pos = pos | CNT_W'(k);
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_shift)
        begin
            case (req_reg.mode)
                crot_pkg::MODE_ADD:
                begin
                    if (!full)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                crot_pkg::MODE_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign pos_pad = {7'd0, pos};
    assign cnt_pad = {7'd0, count_next};

    always_comb
    begin
        result_next             = '0;
        result_next.entry_count = cnt_pad[6:0];
        case (req_reg.mode)
            crot_pkg::MODE_CHECK:
            begin
                result_next.overlap_found = |hit;
            end
            crot_pkg::MODE_ADD:
            begin
                if (full)
                begin
                    result_next.table_full = 1'b1;
                end
                else
                begin
                    result_next.insert_position = pos_pad[6:0];
                end
            end
            default:
            begin
                result_next.overlap_found = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crot_pkg::ST_IDLE;
            count_reg <= '0;
            exact_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= do_shift;
            if (cfg_we)
            begin
                exact_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= item;
        end
        if (do_shift)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/crot_checker.sv =====
// ----------------------------------------------------------------------------
// crot_checker
// Port-level checks of the case range overlap table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "case_range_overlap_table_assert.svh"

module crot_port_checker #(
    parameter int MAX_CASES = crot_pkg::MAX_CASES
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input crot_pkg::result_t result
);

    // An accepted item raises busy, and the busy state ends with a result on done.
    `CROT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `CROT_ASSERT_NEXT(a_busy_done, busy, done && !busy, "busy cycle did not end in a result")
    // A refused add reports a full table and no position.
    `CROT_ASSERT_NOW(a_full_count, done && result.table_full,
        (result.entry_count == 7'(MAX_CASES)) && (result.insert_position == 7'd0),
        "full flag with wrong count or position")
    // Overlap comes only from check mode, which never inserts.
    `CROT_ASSERT_NOW(a_overlap_alone, done && result.overlap_found,
        !result.table_full && (result.insert_position == 7'd0),
        "overlap reported together with an insertion")

endmodule

bind case_range_overlap_table crot_port_checker #(
    .MAX_CASES (MAX_CASES)
) u_crot_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== bench/crot_checker.sv =====
// ----------------------------------------------------------------------------
// crot_checker
// Watches the item, result and register ports of the case range overlap
// table. It keeps its own copy of the interval table and predicts each
// result, then compares each result with the oldest one still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crot_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  crot_pkg::in_item_t item,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               done,
    input  crot_pkg::result_t  result,
    output int                 fail_count,
    output int                 results_owed
);

    logic [1:0]         slot_kind [crot_pkg::MAX_CASES];
    logic signed [31:0] slot_lo   [crot_pkg::MAX_CASES];
    logic signed [31:0] slot_hi   [crot_pkg::MAX_CASES];
    int                 slot_count;
    logic               exact_mode;
    crot_pkg::result_t  owed_results [$];
    crot_pkg::result_t  want;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // True when (k, lo, hi) shares a value with slot idx; exact mode: equal values only.
    function automatic logic hits_slot(input int idx, input logic [1:0] k,
                                       input logic signed [31:0] lo,
                                       input logic signed [31:0] hi);
        logic [1:0]         sk;
        logic signed [31:0] sl;
        logic signed [31:0] sh;
        logic               hit;
        sk  = slot_kind[idx];
        sl  = slot_lo[idx];
        sh  = slot_hi[idx];
        hit = 1'b0;
        if (exact_mode)
        begin
            hit = (k == crot_pkg::KIND_VAL) && (sk == crot_pkg::KIND_VAL) && (lo == sl);
        end
        else
        begin
            case (k)
                crot_pkg::KIND_VAL:
                begin
                    case (sk)
                        crot_pkg::KIND_VAL: hit = (lo == sl);
                        crot_pkg::KIND_MIN: hit = (lo >= sl);
                        crot_pkg::KIND_MAX: hit = (lo <= sh);
                        default:            hit = (lo >= sl) && (lo <= sh);
                    endcase
                end
                crot_pkg::KIND_MIN:
                begin
                    if (sk == crot_pkg::KIND_MIN)
                        hit = 1'b1;
                    else if (sk == crot_pkg::KIND_VAL)
                        hit = (lo <= sl);
                    else
                        hit = (lo <= sh);
                end
                crot_pkg::KIND_MAX:
                begin
                    hit = (sk == crot_pkg::KIND_MAX) ? 1'b1 : (hi >= sl);
                end
                default:
                begin
                    case (sk)
                        crot_pkg::KIND_VAL: hit = (lo <= sl) && (hi >= sl);
                        crot_pkg::KIND_MIN: hit = (hi >= sl);
                        crot_pkg::KIND_MAX: hit = (lo <= sh);
                        default:            hit = (lo <= sh) && (hi >= sl);
                    endcase
                end
            endcase
        end
        return hit;
    endfunction

    // True when slot idx sorts above the new interval, so the new one goes before it.
    // A new min interval never goes in front of a slot, and a max slot never sorts above one.
    function automatic logic slot_sorts_above(input int idx, input logic [1:0] k,
                                              input logic signed [31:0] lo,
                                              input logic signed [31:0] hi);
        logic [1:0]         sk;
        logic signed [31:0] sl;
        logic signed [31:0] sh;
        logic               above;
        sk    = slot_kind[idx];
        sl    = slot_lo[idx];
        sh    = slot_hi[idx];
        above = 1'b0;
        if (k != crot_pkg::KIND_MIN)
        begin
            case (sk)
                crot_pkg::KIND_VAL:
                begin
                    case (k)
                        crot_pkg::KIND_VAL: above = (sl > lo);
                        crot_pkg::KIND_MAX: above = (sl > hi);
                        default:            above = (sl >= lo) && (sl > hi);
                    endcase
                end
                crot_pkg::KIND_MIN:
                begin
                    above = (k == crot_pkg::KIND_VAL) ? (sl > lo) : (sl > hi);
                end
                crot_pkg::KIND_MAX:
                begin
                    above = 1'b0;
                end
                default:
                begin
                    case (k)
                        crot_pkg::KIND_VAL: above = (sh >= lo) && (sl > lo);
                        crot_pkg::KIND_MAX: above = (sl > hi);
                        default:            above = (sh >= lo) && (sl > hi);
                    endcase
                end
            endcase
        end
        return above;
    endfunction

    // Applies one item to the table copy and returns the result it must produce.
    function automatic crot_pkg::result_t table_update(input crot_pkg::in_item_t it);
        crot_pkg::result_t r;
        int                slot;
        int                i;
        logic              found;
        r     = '0;
        found = 1'b0;
        case (it.mode)
            crot_pkg::MODE_CHECK:
            begin
                for (i = 0; i < slot_count; i++)
                    if (hits_slot(i, it.case_kind, it.low_bound, it.high_bound))
                        found = 1'b1;
                r.overlap_found = found;
            end
            crot_pkg::MODE_ADD:
            begin
                if (slot_count >= crot_pkg::MAX_CASES)
                begin
                    r.table_full = 1'b1;
                end
                else
                begin
                    slot = slot_count;
                    for (i = 0; i < slot_count; i++)
                    begin
                        if (!found &&
                            slot_sorts_above(i, it.case_kind, it.low_bound, it.high_bound))
                        begin
                            slot  = i;
                            found = 1'b1;
                        end
                    end
                    for (i = slot_count; i > slot; i--)
                    begin
                        slot_kind[i] = slot_kind[i - 1];
                        slot_lo[i]   = slot_lo[i - 1];
                        slot_hi[i]   = slot_hi[i - 1];
                    end
                    slot_kind[slot] = it.case_kind;
                    slot_lo[slot]   = it.low_bound;
                    slot_hi[slot]   = it.high_bound;
                    slot_count++;
                    r.insert_position = 7'(slot);
                end
            end
            crot_pkg::MODE_CLEAR:
            begin
                slot_count = 0;
            end
            default:
            begin
            end
        endcase
        r.entry_count = 7'(slot_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count = 0;
            exact_mode = 1'b0;
            owed_results.delete();
            results_owed <= 0;
        end
        else
        begin
            if (done)
            begin
                if (owed_results.size() == 0)
                begin
                    flag_error("result strobe with no item outstanding");
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (result.overlap_found !== want.overlap_found)
                        flag_error($sformatf("overlap_found got %b want %b",
                                             result.overlap_found, want.overlap_found));
                    if (result.insert_position !== want.insert_position)
                        flag_error($sformatf("insert_position got %0d want %0d",
                                             result.insert_position, want.insert_position));
                    if (result.table_full !== want.table_full)
                        flag_error($sformatf("table_full got %b want %b",
                                             result.table_full, want.table_full));
                    if (result.entry_count !== want.entry_count)
                        flag_error($sformatf("entry_count got %0d want %0d",
                                             result.entry_count, want.entry_count));
                end
            end
            if (cfg_we)
                exact_mode = cfg_wdata;
            if (start && !busy)
                owed_results.push_back(table_update(item));
            results_owed <= owed_results.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the case range overlap table. A directed set of items covers
// the bound extremes, every mode and kind and the exact-only register; random
// phases then mix adds, checks, clears and unused modes under changing register values.
// The sender idles in random bursts; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int                 RAND_PHASES = 8;
    localparam int                 PHASE_ITEMS = 135;
    localparam int                 MAX_GAP     = 12;
    localparam int                 QUIET_LIMIT = 500;
    localparam logic [1:0]         MODE_UNUSED = 2'd3;
    localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX     = 32'sh7FFF_FFFF;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_wdata = 1'b0;
    crot_pkg::in_item_t item      = '0;
    logic               busy;
    logic               done;
    crot_pkg::result_t  result;
    int                 fail_count;
    int                 results_owed;
    int                 quiet_cycles = 0;
    int                 burst_left   = 0;

    always #4 clk = ~clk;

    case_range_overlap_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    crot_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .result       (result),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Bounds cluster near zero so that intervals meet often.
    function automatic logic signed [31:0] pick_bound();
        int                 sel;
        int                 v;
        logic signed [31:0] b;
        sel = $urandom_range(0, 19);
        if (sel < 10)
        begin
            v = $urandom_range(0, 40);
            b = v - 20;
        end
        else if (sel < 13)
        begin
            case ($urandom_range(0, 5))
                0:       b = S32_MIN;
                1:       b = S32_MAX;
                2:       b = S32_MIN + 1;
                3:       b = S32_MAX - 1;
                4:       b = 0;
                default: b = -1;
            endcase
        end
        else
        begin
            b = $urandom;
        end
        return b;
    endfunction

    task automatic send(input logic [1:0] m, input logic [1:0] k,
                        input logic signed [31:0] lo, input logic signed [31:0] hi);
        crot_pkg::in_item_t it;
        int                 gap;
        it.mode       = m;
        it.case_kind  = k;
        it.low_bound  = lo;
        it.high_bound = hi;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        burst_left--;
    endtask

    // Stops sending and lets every owed result come back.
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_exact(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int                 ph;
        int                 n;
        int                 r;
        int                 clear_pct;
        int                 add_pct;
        logic [1:0]         m;
        logic [1:0]         k;
        logic signed [31:0] lo;
        logic signed [31:0] hi;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_exact(1'b0);

        send(crot_pkg::MODE_CHECK, crot_pkg::KIND_VAL, 0, 0);
        send(crot_pkg::MODE_ADD,   crot_pkg::KIND_VAL, 0, S32_MAX);
        send(crot_pkg::MODE_ADD,   crot_pkg::KIND_VAL, S32_MAX, 0);
        send(crot_pkg::MODE_ADD,   crot_pkg::KIND_VAL, S32_MIN, S32_MIN);
        send(crot_pkg::MODE_ADD,   crot_pkg::KIND_MIN, 100, S32_MIN);
        send(crot_pkg::MODE_ADD,   crot_pkg::KIND_MAX, S32_MAX, -100);
        send(crot_pkg::MODE_ADD,   crot_pkg::KIND_RNG, -5, 5);
        send(crot_pkg::MODE_ADD,   crot_pkg::KIND_RNG, 10, -10);
        // Adding a duplicate is not checked for overlap; it is stored anyway.
        send(crot_pkg::MODE_ADD,   crot_pkg::KIND_VAL, 0, -1);
        send(crot_pkg::MODE_CHECK, crot_pkg::KIND_VAL, 0, 0);
        send(crot_pkg::MODE_CHECK, crot_pkg::KIND_MIN, S32_MAX, 0);
        send(crot_pkg::MODE_CHECK, crot_pkg::KIND_MAX, 0, S32_MIN);
        send(crot_pkg::MODE_CHECK, crot_pkg::KIND_RNG, 50, 60);
        send(crot_pkg::MODE_CHECK, crot_pkg::KIND_RNG, 60, 50);
        send(MODE_UNUSED,          crot_pkg::KIND_RNG, -1, -1);
        send(crot_pkg::MODE_CLEAR, crot_pkg::KIND_VAL, 0, 0);
        send(crot_pkg::MODE_CHECK, crot_pkg::KIND_VAL, S32_MAX, S32_MAX);
        send(crot_pkg::MODE_ADD,   crot_pkg::KIND_RNG, S32_MIN, S32_MAX);
        settle();

        set_exact(1'b1);
        send(crot_pkg::MODE_ADD,   crot_pkg::KIND_VAL, 7, 7);
        send(crot_pkg::MODE_CHECK, crot_pkg::KIND_VAL, 7, 0);
        send(crot_pkg::MODE_CHECK, crot_pkg::KIND_RNG, 0, 10);
        send(crot_pkg::MODE_CHECK, crot_pkg::KIND_MIN, S32_MIN, S32_MAX);
        send(crot_pkg::MODE_CLEAR, crot_pkg::KIND_VAL, 0, 0);

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            settle();
            set_exact(ph % 3 == 2);
            // Every fourth phase has no clears, so the table fills and refuses adds.
            clear_pct = (ph % 4 == 0) ? 0 : ((ph % 2 == 1) ? 3 : 1);
            add_pct   = (ph % 4 == 0) ? 70 : 45;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < clear_pct)
                    m = crot_pkg::MODE_CLEAR;
                else if (r < clear_pct + 2)
                    m = MODE_UNUSED;
                else if (r < clear_pct + 2 + add_pct)
                    m = crot_pkg::MODE_ADD;
                else
                    m = crot_pkg::MODE_CHECK;
                k  = 2'($urandom_range(0, 3));
                lo = pick_bound();
                if ($urandom_range(0, 9) < 7)
                    hi = lo + $urandom_range(0, 15);
                else
                    hi = pick_bound();
                send(m, k, lo, hi);
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== case_range_overlap_table.f =====
+incdir+src
src/crot_pkg.sv
src/crot_cell.sv
src/case_range_overlap_table.sv
src/crot_checker.sv
bench/crot_checker.sv
bench/tb_top.sv
